// ===== hdl/cwd_pkg.sv =====
// Shared types, constants and the CRC-8 byte function for the word deframer.
package cwd_pkg;

	localparam int unsigned CwdMaxWords   = 32;
	localparam int unsigned CwdCounterSpan = 32;
	localparam int unsigned CwdWordCap    =
		(CwdMaxWords < CwdCounterSpan) ? CwdMaxWords : CwdCounterSpan;

	localparam int unsigned FrameWordsW = 6;
	localparam int unsigned WordIdxW    = 5;
	localparam int unsigned ByteW       = 8;
	localparam int unsigned WordW       = 16;

	localparam logic [FrameWordsW-1:0] FrameWordsReset = 6'd10;
	localparam logic [FrameWordsW-1:0] FrameWordsCap   = FrameWordsW'(CwdWordCap);

	localparam logic [ByteW-1:0] CrcPoly = 8'h31;
	localparam logic [ByteW-1:0] CrcInit = 8'hFF;

	typedef enum logic [1:0] {
		POS_HIGH = 2'd0,
		POS_LOW  = 2'd1,
		POS_CRC  = 2'd2
	} cwd_pos_t;

	typedef struct packed {
		logic [WordW-1:0]    data_word;
		logic                crc_ok;
		logic [ByteW-1:0]    computed_crc;
		logic [WordIdxW-1:0] word_index;
		logic                last_word;
		logic                frame_error;
	} cwd_result_t;

	// MSB-first CRC-8 update over one byte
	function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
	                                              input logic [ByteW-1:0] b);
		logic [ByteW-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < ByteW; k++) begin
			if (v[ByteW-1]) begin
				v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
			end else begin
				v = {v[ByteW-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ===== hdl/cwd_frame_ctrl.sv =====
// Byte position tracking, running CRC, word counter and result formation.
module cwd_frame_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [cwd_pkg::ByteW-1:0]     item_byte,
	input  logic                          item_start,
	input  logic [cwd_pkg::FrameWordsW-1:0] frame_words,
	input  logic                          out_free,
	output logic                          item_take,
	output logic                          res_valid,
	output cwd_pkg::cwd_result_t          res
);

	cwd_pkg::cwd_pos_t                pos_q;
	cwd_pkg::cwd_pos_t                pos_e;
	logic [cwd_pkg::WordIdxW-1:0]     cnt_q;
	logic [cwd_pkg::WordIdxW-1:0]     cnt_e;
	logic                             err_q;
	logic                             err_e;
	logic [cwd_pkg::ByteW-1:0]        held_high_q;
	logic [cwd_pkg::ByteW-1:0]        held_low_q;
	logic [cwd_pkg::ByteW-1:0]        crc_q;
	logic [cwd_pkg::FrameWordsW-1:0]  eff_words;
	logic [cwd_pkg::FrameWordsW-1:0]  cnt_inc;
	logic                             is_crc;
	logic                             ok;
	logic                             last;
	logic                             err_new;

	// frame start clears position, count and error ahead of this byte
	assign pos_e = item_start ? cwd_pkg::POS_HIGH : pos_q;
	assign cnt_e = item_start ? '0 : cnt_q;
	assign err_e = item_start ? 1'b0 : err_q;

	always_comb begin
		if (frame_words == '0) begin
			eff_words = cwd_pkg::FrameWordsW'(1);
		end else if (frame_words > cwd_pkg::FrameWordsCap) begin
			eff_words = cwd_pkg::FrameWordsCap;
		end else begin
			eff_words = frame_words;
		end
	end

	assign is_crc  = (pos_e == cwd_pkg::POS_CRC);
	assign cnt_inc = {1'b0, cnt_e} + cwd_pkg::FrameWordsW'(1);
	assign last    = (cnt_inc >= eff_words);
	assign ok      = (crc_q == item_byte);
	assign err_new = err_e | ~ok;

	// non-CRC bytes only update state, so they never wait on the output
	assign item_take = item_valid && (!is_crc || out_free);
	assign res_valid = item_valid && is_crc && out_free;

	assign res.data_word    = {held_high_q, held_low_q};
	assign res.crc_ok       = ok;
	assign res.computed_crc = crc_q;
	assign res.word_index   = cnt_e;
	assign res.last_word    = last;
	assign res.frame_error  = err_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= cwd_pkg::POS_HIGH;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (item_take) begin
			unique case (pos_e)
				cwd_pkg::POS_LOW: begin
					pos_q <= cwd_pkg::POS_CRC;
					cnt_q <= cnt_e;
					err_q <= err_e;
				end
				cwd_pkg::POS_CRC: begin
					pos_q <= cwd_pkg::POS_HIGH;
					if (last) begin
						cnt_q <= '0;
						err_q <= 1'b0;
					end else begin
						cnt_q <= cnt_inc[cwd_pkg::WordIdxW-1:0];
						err_q <= err_new;
					end
				end
				default: begin
					pos_q <= cwd_pkg::POS_LOW;
					cnt_q <= cnt_e;
					err_q <= err_e;
				end
			endcase
		end
	end

	// hold the data bytes and fold each into the running CRC as it arrives
	always_ff @(posedge clk) begin
		if (item_take) begin
			case (pos_e)
				cwd_pkg::POS_LOW: begin
					held_low_q <= item_byte;
					crc_q      <= cwd_pkg::crc8_byte(crc_q, item_byte);
				end
				cwd_pkg::POS_CRC: begin
				end
				default: begin
					held_high_q <= item_byte;
					crc_q       <= cwd_pkg::crc8_byte(cwd_pkg::CrcInit, item_byte);
				end
			endcase
		end
	end

endmodule

// ===== hdl/cwd_out_reg.sv =====
// Output result register driving the master-side stream.
module cwd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  cwd_pkg::cwd_result_t res,
	output logic                 out_free,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,
	output logic [1:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	logic                 valid_s2;
	cwd_pkg::cwd_result_t res_s2;

	assign out_free = !valid_s2 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.word_index, res_s2.computed_crc, res_s2.data_word};
	assign m_axis_tuser  = {res_s2.frame_error, res_s2.crc_ok};
	assign m_axis_tlast  = res_s2.last_word;

endmodule

// ===== hdl/crc8_checked_word_deframer_unit.sv =====
// Top level of the CRC-8 checked 16-bit word deframer.
// Bytes come in threes (data high, data low, CRC-8 with polynomial 0x31, init 0xFF, no
// reflection, no final XOR); every third byte yields one output transaction carrying the
// big-endian word, the computed CRC, the match flag, the word index, a last-word mark
// (tlast) and a sticky frame error. One byte is accepted per cycle unless the output
// stalls; a byte passes an input register and then the output register. The running CRC
// is folded one byte per cycle as data bytes arrive, so the CRC byte only needs a compare.
// Only CRC bytes wait on a stalled output.
module crc8_checked_word_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cwd_pkg::FrameWordsW-1:0] cfg_wdata,   // frame_words
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
	input  logic                            s_axis_tuser,  // [0] frame_start
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] data_word, [23:16] computed_crc, [28:24] word_index, [31:29] zero
	output logic [31:0]                     m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,  // [0] crc_ok, [1] frame_error
	output logic                            m_axis_tlast   // last_word
);

	logic [cwd_pkg::FrameWordsW-1:0] frame_words_q;
	logic                            valid_s1;
	logic [cwd_pkg::ByteW-1:0]       byte_s1;
	logic                            start_s1;
	logic                            item_take;
	logic                            res_valid;
	logic                            out_free;
	cwd_pkg::cwd_result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q <= cwd_pkg::FrameWordsReset;
		end else if (cfg_we) begin
			frame_words_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	cwd_frame_ctrl u_frame_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item_byte   (byte_s1),
		.item_start  (start_s1),
		.frame_words (frame_words_q),
		.out_free    (out_free),
		.item_take   (item_take),
		.res_valid   (res_valid),
		.res         (res)
	);

	cwd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (res_valid),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== hdl/cwd_checker.sv =====
// Port-level checks for the word deframer, bound to the top level.
module cwd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled output transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// a failed check always raises the frame error
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("crc mismatch without frame error");

	// the first word of a frame carries only its own check outcome
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28:24] == 5'd0 && m_axis_tuser[0]
			|-> !m_axis_tuser[1])
		else $error("stale frame error on first word");

	// the counter span forces a frame end at the top index
	a_top_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28:24] == 5'd31 |-> m_axis_tlast)
		else $error("word index 31 not marked last");

endmodule

bind crc8_checked_word_deframer_unit cwd_checker u_cwd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
